// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/vcc_pkg.sv =====
package vcc_pkg;

  // Axis count and indexes
  localparam int AXES   = 3;
  localparam int AX_X   = 0;
  localparam int AX_Y   = 1;
  localparam int AX_YAW = 2;

  // Field widths
  localparam int VEL_W   = 16;
  localparam int GAIN_W  = 31;
  localparam int DB_W    = 15;
  localparam int ALPHA_W = 16;
  localparam int STEP_W  = 16;
  localparam int TICK_W  = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_X   = 3'd0,
    REG_GAIN_Y   = 3'd1,
    REG_GAIN_YAW = 3'd2,
    REG_DEADBAND = 3'd3,
    REG_ALPHA    = 3'd4,
    REG_MAX_STEP = 3'd5,
    REG_TIMEOUT  = 3'd6
  } cfg_reg_t;

  // Reset values
  localparam logic [GAIN_W-1:0]  GAIN_RST    = 31'd2147484;
  localparam logic [DB_W-1:0]    DB_RST      = 15'd1638;
  localparam logic [ALPHA_W-1:0] ALPHA_RST   = 16'd13107;
  localparam logic [STEP_W-1:0]  STEP_RST    = 16'd1638;
  localparam logic [TICK_W-1:0]  TIMEOUT_RST = 8'd3;

  // Item opcodes
  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Q1.15 saturation magnitudes
  localparam logic [VEL_W-1:0] POS_LIM = 16'h7FFF;
  localparam logic [VEL_W-1:0] NEG_LIM = 16'h8000;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic [AXES-1:0][GAIN_W-1:0] gain;
    logic [DB_W-1:0]             deadband;
    logic [ALPHA_W-1:0]          alpha;
    logic [STEP_W-1:0]           max_step;
    logic [TICK_W-1:0]           timeout;
  } cfg_t;

endpackage

// ===== design/vcc_if.sv =====
// Command/tick channel
interface vcc_in_if import vcc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [VEL_W-1:0] cmd_x;
  logic signed [VEL_W-1:0] cmd_y;
  logic signed [VEL_W-1:0] cmd_yaw;

  modport source(output valid, op, cmd_x, cmd_y, cmd_yaw, input ready);
  modport sink(input valid, op, cmd_x, cmd_y, cmd_yaw, output ready);
endinterface

// Drive result channel
interface vcc_out_if import vcc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    stopped;
  logic signed [VEL_W-1:0] out_x;
  logic signed [VEL_W-1:0] out_y;
  logic signed [VEL_W-1:0] out_yaw;

  modport source(output valid, stopped, out_x, out_y, out_yaw, input ready);
  modport sink(input valid, stopped, out_x, out_y, out_yaw, output ready);
endinterface

// ===== design/vcc_cfg.sv =====
module vcc_cfg import vcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  // Register file, upper data bits dropped per register width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain     <= {AXES{GAIN_RST}};
      cfg.deadband <= DB_RST;
      cfg.alpha    <= ALPHA_RST;
      cfg.max_step <= STEP_RST;
      cfg.timeout  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_GAIN_X:   cfg.gain[AX_X]   <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_Y:   cfg.gain[AX_Y]   <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_YAW: cfg.gain[AX_YAW] <= cfg_wdata[GAIN_W-1:0];
        REG_DEADBAND: cfg.deadband     <= cfg_wdata[DB_W-1:0];
        REG_ALPHA:    cfg.alpha        <= cfg_wdata[ALPHA_W-1:0];
        REG_MAX_STEP: cfg.max_step     <= cfg_wdata[STEP_W-1:0];
        REG_TIMEOUT:  cfg.timeout      <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/vcc_norm.sv =====
module vcc_norm import vcc_pkg::*; (
  input  logic signed [VEL_W-1:0] cmd,
  input  logic [GAIN_W-1:0]       gain,
  input  logic [DB_W-1:0]         deadband,
  output logic signed [VEL_W-1:0] target
);

  logic                      neg;
  logic [VEL_W-1:0]          mag;
  logic [VEL_W+GAIN_W-1:0]   prod;
  logic [GAIN_W-1:0]         q;
  logic [VEL_W-1:0]          lim;
  logic [VEL_W-1:0]          qs;
  logic                      in_db;

  // Sign-magnitude scale, truncation toward zero
  assign neg  = cmd[VEL_W-1];
  assign mag  = neg ? (~cmd + 1'b1) : cmd;
  assign prod = mag * gain;
  assign q    = prod[VEL_W+GAIN_W-1:VEL_W];

  // Saturate to Q1.15, then deadband
  assign lim   = neg ? NEG_LIM : POS_LIM;
  assign qs    = (q > GAIN_W'(lim)) ? lim : q[VEL_W-1:0];
  assign in_db = qs < {1'b0, deadband};

  assign target = in_db ? '0 : (neg ? (~qs + 1'b1) : qs);

endmodule

// ===== design/vcc_filt.sv =====
module vcc_filt import vcc_pkg::*; (
  input  logic signed [VEL_W-1:0] smooth,
  input  logic signed [VEL_W-1:0] target,
  input  logic signed [VEL_W-1:0] last,
  input  logic [ALPHA_W-1:0]      alpha,
  input  logic [STEP_W-1:0]       max_step,
  output logic signed [VEL_W-1:0] result
);

  logic signed [VEL_W:0]           diff;
  logic signed [VEL_W+ALPHA_W+1:0] prod;
  logic signed [VEL_W+1:0]         adj;
  logic signed [VEL_W+2:0]         sm;
  logic signed [VEL_W+2:0]         last_e;
  logic signed [VEL_W+2:0]         step_e;
  logic signed [VEL_W+2:0]         d;
  logic signed [VEL_W+2:0]         lim;

  // EMA as s + floor(alpha * (t - s) / 2^16)
  assign diff = {target[VEL_W-1], target} - {smooth[VEL_W-1], smooth};
  assign prod = diff * $signed({1'b0, alpha});
  assign adj  = prod[VEL_W+ALPHA_W+1:ALPHA_W];
  assign sm   = {{3{smooth[VEL_W-1]}}, smooth} + {adj[VEL_W+1], adj};

  // Slew limit against the last sent value
  assign last_e = {{3{last[VEL_W-1]}}, last};
  assign step_e = {3'b000, max_step};
  assign d      = sm - last_e;

  always_comb begin
    if (d > step_e) begin
      lim = last_e + step_e;
    end else if (d < -step_e) begin
      lim = last_e - step_e;
    end else begin
      lim = sm;
    end
  end

  // Stays inside Q1.15 range by construction
  assign result = lim[VEL_W-1:0];

endmodule

// ===== design/velocity_command_conditioner_core.sv =====
// Channel   Dir  Word
// command   in   op, cmd_x, cmd_y, cmd_yaw (op 0 command, op 1 tick)
// drive     out  stopped, out_x, out_y, out_yaw (one word per tick)
// cfg_*     in   write enable, register index, write data
//
// One word is taken per clock unless a stalled result holds a tick; words pass the input
// register and one multiply-add path per axis; tick results land in the result register.
// A tick leaves the input register only when the result register is free or being read.
// Reset is synchronous and clears the filter state, tick count, valid flags and config.
// A stalled result holds a tick in the input register and every word behind it;
// a command in the input register still passes.
`include "assert_macros.svh"

module velocity_command_conditioner_core import vcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  vcc_in_if.sink                command,
  vcc_out_if.source             drive
);

  cfg_t cfg;

  // Input register
  logic                    in_valid;
  logic                    in_op;
  logic signed [VEL_W-1:0] in_cmd [AXES];
  logic                    in_ready;
  logic                    fire;

  // Filter state
  logic signed [VEL_W-1:0] target [AXES];
  logic signed [VEL_W-1:0] smooth [AXES];
  logic signed [VEL_W-1:0] last   [AXES];
  logic [TICK_W-1:0]       ticks;
  logic [TICK_W-1:0]       ticks_next;
  logic                    trip;

  // Datapath results
  logic signed [VEL_W-1:0] norm_out [AXES];
  logic signed [VEL_W-1:0] filt_out [AXES];

  // Result register
  logic                    res_valid;
  logic                    res_stopped;
  logic signed [VEL_W-1:0] res_out [AXES];

  // Check helpers
  logic                    cmd_fire;
  logic                    tick_fire;
  logic                    stop_ok;

  vcc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Per-axis datapath
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    vcc_norm u_norm (
      .cmd      (in_cmd[a]),
      .gain     (cfg.gain[a]),
      .deadband (cfg.deadband),
      .target   (norm_out[a])
    );

    vcc_filt u_filt (
      .smooth   (smooth[a]),
      .target   (target[a]),
      .last     (last[a]),
      .alpha    (cfg.alpha),
      .max_step (cfg.max_step),
      .result   (filt_out[a])
    );
  end

  // Commands in the input register never wait; ticks wait for room in the result register
  assign fire     = in_valid && (in_op == OP_CMD || !res_valid || drive.ready);
  assign in_ready = !in_valid || fire;
  assign command.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= command.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && command.valid) begin
      in_op          <= command.op;
      in_cmd[AX_X]   <= command.cmd_x;
      in_cmd[AX_Y]   <= command.cmd_y;
      in_cmd[AX_YAW] <= command.cmd_yaw;
    end
  end

  // Watchdog
  assign ticks_next = (ticks == TICK_MAX) ? ticks : ticks + 1'b1;
  assign trip       = ticks_next > cfg.timeout;

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks <= '0;
      for (int i = 0; i < AXES; i++) begin
        target[i] <= '0;
        smooth[i] <= '0;
        last[i]   <= '0;
      end
    end else if (fire) begin
      if (in_op == OP_CMD) begin
        ticks <= '0;
        for (int i = 0; i < AXES; i++) begin
          target[i] <= norm_out[i];
        end
      end else begin
        ticks <= ticks_next;
        for (int i = 0; i < AXES; i++) begin
          if (trip) begin
            smooth[i] <= '0;
          end else begin
            smooth[i] <= filt_out[i];
            last[i]   <= filt_out[i];
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && in_op == OP_TICK) begin
      res_valid <= 1'b1;
    end else if (drive.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_op == OP_TICK) begin
      res_stopped <= trip;
      for (int i = 0; i < AXES; i++) begin
        res_out[i] <= trip ? '0 : filt_out[i];
      end
    end
  end

  assign drive.valid   = res_valid;
  assign drive.stopped = res_stopped;
  assign drive.out_x   = res_out[AX_X];
  assign drive.out_y   = res_out[AX_Y];
  assign drive.out_yaw = res_out[AX_YAW];

  // Checks
  assign cmd_fire  = fire && in_op == OP_CMD;
  assign tick_fire = fire && in_op == OP_TICK;
  assign stop_ok   = !(res_valid && res_stopped) ||
                     (res_out[AX_X] == '0 && res_out[AX_Y] == '0 && res_out[AX_YAW] == '0);

  `ASSERT_ALWAYS(a_stop_zero, clk, rst, stop_ok, "stopped word with nonzero drive")
  `ASSERT_NEXT(a_cmd_clears, clk, rst, cmd_fire, ticks == '0, "tick count not cleared by command")
  `ASSERT_NEXT(a_tick_result, clk, rst, tick_fire, res_valid, "tick produced no result")
  `ASSERT_NEXT(a_ticks_mono, clk, rst, !cmd_fire, ticks >= $past(ticks), "tick count went down")

endmodule
